>>> rtl/fpa_pkg.sv
// Shared types and constants for the fit-policy partition allocator.
`default_nettype none
package fpa_pkg;

  // Search policy codes; the fourth code falls back to first fit.
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  // Input operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

  localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  // Control handed to the shared compare unit each scan cycle.
  typedef struct packed {
    logic       cand_valid;
    logic       have_pick;
    logic [1:0] policy;
  } cmp_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/fpa_if.sv
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  entry_index;
  logic [15:0] item_size;
  logic        last_in_batch;

  modport source (output valid, operation, entry_index, item_size, last_in_batch,
                  input ready);
  modport sink   (input valid, operation, entry_index, item_size, last_in_batch,
                  output ready);
endinterface

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [3:0]  chosen_block;
  logic [15:0] capacity_left;
  logic        batch_end;

  modport source (output valid, granted, chosen_block, capacity_left, batch_end,
                  input ready);
  modport sink   (input valid, granted, chosen_block, capacity_left, batch_end,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/fpa_cap_mem.sv
// Free-capacity table: one write port, one registered read port.
`default_nettype none
module fpa_cap_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/fpa_fit_cmp.sv
// Shared fit comparator: decides whether a candidate replaces the current pick.
`default_nettype none
module fpa_fit_cmp #(
  parameter int unsigned WIDTH = 16
) (
  input  wire fpa_pkg::cmp_ctrl_t ctrl_i,
  input  wire logic [WIDTH-1:0]   cand_i,
  input  wire logic [WIDTH-1:0]   best_i,
  input  wire logic [WIDTH-1:0]   req_i,
  output logic                    take_o
);
  import fpa_pkg::*;

  logic fits;
  logic better;

  assign fits = (cand_i >= req_i);

  always_comb begin
    case (ctrl_i.policy)
      FIT_BEST:  better = (cand_i < best_i);
      FIT_WORST: better = (cand_i > best_i);
      default:   better = 1'b0;  // first fit keeps the earliest hit
    endcase
  end

  assign take_o = ctrl_i.cand_valid && fits && (!ctrl_i.have_pick || better);

endmodule
`default_nettype wire

>>> rtl/fit_policy_partition_allocator_top.sv
// Top level of the fit-policy partition allocator.
// Flow: a load word is written to the table as it is accepted; an allocate word scans
//   count partitions (count = blocks_in_use saturated to MAX_BLOCKS), then the write
//   state loads the result word once any held result is taken. No word is accepted
//   meanwhile; the single read port and shared comparator walk one partition per cycle.
// Reset: async active low; clears sequencer, result valid and config (first fit, 16).
// The capacity table has no reset; entries are meaningful once loaded.
`default_nettype none
module fit_policy_partition_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  fpa_in_if.sink                               in_if,
  fpa_out_if.source                            out_if
);
  import fpa_pkg::*;

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_N = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CNT_W = (CNT_N > 5) ? CNT_N : 5;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  // Configuration registers.
  logic [1:0] policy_q;
  logic [4:0] blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= FIT_FIRST;
      blocks_q <= BLOCKS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIT_POLICY:    policy_q <= cfg_wdata_i[1:0];
        REG_BLOCKS_IN_USE: blocks_q <= cfg_wdata_i[4:0];
        default:           ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_e               state_q, state_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic [IDX_W-1:0]     last_idx_q, last_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 have_q, have_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic                 last_q, last_d;

  // Result word register.
  logic                 ov_q, ov_d;
  logic                 og_q, og_d;
  logic [3:0]           oblk_q, oblk_d;
  logic [15:0]          ocap_q, ocap_d;
  logic                 oend_q, oend_d;

  // Table port signals.
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] mem_rdata;

  logic                 in_acc;
  logic [CNT_W-1:0]     blocks_ext;
  logic [CNT_W-1:0]     count;
  logic [SIZE_BITS-1:0] cap_left;
  logic                 take;
  cmp_ctrl_t            cmp_ctrl;

  assign in_acc     = in_if.valid && in_if.ready;
  assign blocks_ext = CNT_W'(blocks_q);
  assign count      = (blocks_ext > MAX_CNT) ? MAX_CNT : blocks_ext;
  assign cap_left   = best_q - req_q;

  fpa_cap_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  assign cmp_ctrl.cand_valid = rd_vld_q;
  assign cmp_ctrl.have_pick  = have_q;
  assign cmp_ctrl.policy     = policy_q;

  fpa_fit_cmp #(
    .WIDTH (SIZE_BITS)
  ) u_cmp (
    .ctrl_i (cmp_ctrl),
    .cand_i (mem_rdata),
    .best_i (best_q),
    .req_i  (req_q),
    .take_o (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      have_q   <= have_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    last_idx_q <= last_idx_d;
    rd_idx_q   <= rd_idx_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    req_q      <= req_d;
    last_q     <= last_d;
    og_q       <= og_d;
    oblk_q     <= oblk_d;
    ocap_q     <= ocap_d;
    oend_q     <= oend_d;
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    last_idx_d = last_idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    have_d     = have_q;
    pick_d     = pick_q;
    best_d     = best_q;
    req_d      = req_q;
    last_d     = last_q;
    og_d       = og_q;
    oblk_d     = oblk_q;
    ocap_d     = ocap_q;
    oend_d     = oend_q;
    ov_d       = ov_q && !out_if.ready;
    mem_we     = 1'b0;
    mem_waddr  = pick_q;
    mem_wdata  = cap_left;
    in_if.ready = 1'b0;

    // Candidate read last cycle lands in the comparator now.
    if (take) begin
      have_d = 1'b1;
      pick_d = rd_idx_q;
      best_d = mem_rdata;
    end

    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_acc) begin
          req_d  = SIZE_BITS'(in_if.item_size);
          last_d = in_if.last_in_batch;
          have_d = 1'b0;
          ptr_d  = '0;
          if (in_if.operation == OP_LOAD) begin
            // Out-of-range indexes are dropped.
            mem_we    = (32'(in_if.entry_index) < MAX_BLOCKS);
            mem_waddr = IDX_W'(in_if.entry_index);
            mem_wdata = SIZE_BITS'(in_if.item_size);
          end else if (count == '0) begin
            state_d = ST_WRITE;
          end else begin
            last_idx_d = IDX_W'(count - CNT_W'(1));
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_d = 1'b1;
        rd_idx_d = ptr_q;
        if (ptr_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (!ov_q || out_if.ready) begin
          mem_we = have_q;
          ov_d   = 1'b1;
          og_d   = have_q;
          oblk_d = have_q ? 4'(pick_q) : 4'd0;
          ocap_d = have_q ? 16'(cap_left) : 16'd0;
          oend_d = last_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_if.valid         = ov_q;
  assign out_if.granted       = og_q;
  assign out_if.chosen_block  = oblk_q;
  assign out_if.capacity_left = ocap_q;
  assign out_if.batch_end     = oend_q;

endmodule
`default_nettype wire

>>> rtl/fpa_checker.sv
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_granted,
  input wire logic [3:0]  out_chosen_block,
  input wire logic [15:0] out_capacity_left,
  input wire logic        out_batch_end
);

  // No result word in the cycle after reset is seen held.
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result word valid during reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_granted)
      && $stable(out_chosen_block) && $stable(out_capacity_left)
      && $stable(out_batch_end))
    else $error("stalled result word changed");

  // An accepted allocate word keeps the block busy at least the next cycle.
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_operation |=> !in_ready)
    else $error("request taken during a search");

  // A refused request reports index and capacity as zero.
  a_deny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_granted |-> out_chosen_block == 4'd0
      && out_capacity_left == 16'd0)
    else $error("refused request carries nonzero fields");

endmodule

bind fit_policy_partition_allocator_top fpa_checker u_fpa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_operation      (in_if.operation),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_granted       (out_if.granted),
  .out_chosen_block  (out_if.chosen_block),
  .out_capacity_left (out_if.capacity_left),
  .out_batch_end     (out_if.batch_end)
);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the fit-policy partition allocator: directed and random words.
module tb_top;
  import fpa_pkg::*;

  localparam int MAX_BLOCKS     = 16;
  localparam int SIZE_BITS      = 16;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_WORDS   = 900;
  // Leave a margin after the last result before config writes.
  localparam int SETTLE_CYCLES  = 24;
  // Long result back-pressure stretch so the block fills and stalls its input.
  localparam int HOLD_CYCLES    = 400;
  localparam int PRESSURE_AFTER = 300;
  // Cycles with no accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Fourth policy code: not in the enum, falls back to first fit.
  localparam logic [1:0] FIT_RESERVED = 2'd3;

  typedef struct packed {
    op_e                  operation;
    logic [3:0]           entry_index;
    logic [SIZE_BITS-1:0] item_size;
    logic                 last_in_batch;
  } alloc_req_t;

  typedef struct packed {
    logic                 granted;
    logic [3:0]           chosen_block;
    logic [SIZE_BITS-1:0] capacity_left;
    logic                 batch_end;
  } alloc_res_t;

  // Mix of values used for partition sizes and request sizes within one batch.
  typedef enum int {
    VAL_TINY,   // 0..15: many ties and exact fits
    VAL_MID,    // 0..1000
    VAL_WIDE,   // full 16-bit range
    VAL_EDGE    // 0, 1, 0xFFFE, 0xFFFF
  } value_mix_e;

  // Mirror of the capacity table and config; predicts one result per allocate word.
  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] capacity [MAX_BLOCKS];
    logic [1:0]           policy;
    logic [4:0]           search_count;
    alloc_res_t           expected_q[$];
    int errors, loads, allocs, grants, refusals, checked;

    function new();
      policy       = FIT_FIRST;
      search_count = BLOCKS_IN_USE_RST;
      errors = 0; loads = 0; allocs = 0; grants = 0; refusals = 0; checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FIT_POLICY) begin
        policy = val[1:0];
      end else if (idx == REG_BLOCKS_IN_USE) begin
        search_count = val[4:0];
      end
    endfunction

    function void note_request(alloc_req_t req);
      int         n;
      int         pick;
      int         j;
      alloc_res_t res;
      if (req.operation == OP_LOAD) begin
        capacity[req.entry_index] = req.item_size;
        loads++;
        return;
      end
      allocs++;
      n    = (search_count > MAX_BLOCKS) ? MAX_BLOCKS : search_count;
      pick = -1;
      for (j = 0; j < n; j++) begin
        if (capacity[j] >= req.item_size) begin
          if (pick < 0) begin
            pick = j;
            // first fit (and the reserved code) stops at the first hit
            if (policy != FIT_BEST && policy != FIT_WORST) break;
          end else if (policy == FIT_BEST && capacity[j] < capacity[pick]) begin
            pick = j;
          end else if (policy == FIT_WORST && capacity[j] > capacity[pick]) begin
            pick = j;
          end
        end
      end
      res           = '0;
      res.batch_end = req.last_in_batch;
      if (pick >= 0) begin
        capacity[pick]    = capacity[pick] - req.item_size;
        res.granted       = 1'b1;
        res.chosen_block  = pick[3:0];
        res.capacity_left = capacity[pick];
        grants++;
      end else begin
        refusals++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(alloc_res_t got);
      alloc_res_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no allocate pending: granted %0d block %0d capacity %0d",
               got.granted, got.chosen_block, got.capacity_left);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, actual %0d", want.granted, got.granted);
        errors++;
      end
      if (got.chosen_block !== want.chosen_block) begin
        $error("chosen_block: expected %0d, actual %0d", want.chosen_block, got.chosen_block);
        errors++;
      end
      if (got.capacity_left !== want.capacity_left) begin
        $error("capacity_left: expected %0d, actual %0d", want.capacity_left,
               got.capacity_left);
        errors++;
      end
      if (got.batch_end !== want.batch_end) begin
        $error("batch_end: expected %0d, actual %0d", want.batch_end, got.batch_end);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  fpa_in_if  in_if();
  fpa_out_if out_if();

  alloc_scoreboard sb = new();

  // Idle behavior knobs: 0 = never idle, 1 = light, 2 = heavy.
  int src_mode     = 0;
  int sink_mode    = 0;
  bit hold_request = 1'b0;
  int words_sent   = 0;
  int stall_cycles = 0;
  int phases       = 0;

  fit_policy_partition_allocator_top #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Idle length: mostly a few cycles, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int source_gap();
    if (src_mode == 0) return 0;
    if ($urandom_range(0, 99) < (src_mode == 1 ? 75 : 45)) return 0;
    return gap_len();
  endfunction

  function automatic logic [SIZE_BITS-1:0] draw_size(value_mix_e mix);
    case (mix)
      VAL_TINY: return SIZE_BITS'($urandom_range(0, 15));
      VAL_MID:  return SIZE_BITS'($urandom_range(0, 1000));
      VAL_WIDE: return SIZE_BITS'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Config writes happen only while the block is idle; the mirror follows at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one word; returns in the step of the edge that accepted it, valid still high.
  task automatic send_word(op_e op, logic [3:0] idx, logic [SIZE_BITS-1:0] size,
                           logic last);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.entry_index   <= idx;
    in_if.item_size     <= size;
    in_if.last_in_batch <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
  endtask

  // Loads ignore the batch mark, so it carries random noise here.
  task automatic load_entry(logic [3:0] idx, logic [SIZE_BITS-1:0] size);
    send_word(OP_LOAD, idx, size, 1'($urandom));
  endtask

  // Allocates ignore entry_index, so it carries random noise here.
  task automatic alloc_request(logic [SIZE_BITS-1:0] size, logic last);
    send_word(OP_ALLOC, 4'($urandom), size, last);
  endtask

  // Stop offering, wait for every pending result, then let the scan pipeline drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Monitor: both channels sampled at the clock edge, values from before the edge.
  always @(posedge clk_i) begin : monitor
    alloc_req_t req;
    alloc_res_t res;
    if (rst_ni && in_if.valid && in_if.ready) begin
      req.operation     = op_e'(in_if.operation);
      req.entry_index   = in_if.entry_index;
      req.item_size     = in_if.item_size;
      req.last_in_batch = in_if.last_in_batch;
      sb.note_request(req);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      res.granted       = out_if.granted;
      res.chosen_block  = out_if.chosen_block;
      res.capacity_left = out_if.capacity_left;
      res.batch_end     = out_if.batch_end;
      sb.check_result(res);
    end
  end

  // Watchdog: a run with no progress for too long is a hang.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (sink_mode != 0 &&
                   $urandom_range(0, 99) < (sink_mode == 1 ? 15 : 40)) begin
        stall_left   = gap_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [SIZE_BITS-1:0] seed_caps [MAX_BLOCKS];
    logic [1:0]           policy;
    logic [4:0]           count;
    value_mix_e           mix;
    int                   directed_words;
    int                   span;
    int                   nreq;
    int                   k;
    int                   r;
    bit                   pressure_done;
    logic                 last;

    in_if.valid         <= 1'b0;
    in_if.operation     <= OP_LOAD;
    in_if.entry_index   <= '0;
    in_if.item_size     <= '0;
    in_if.last_in_batch <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_FIT_POLICY;
    cfg_wdata_i         <= '0;
    pressure_done = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part ----
    // Reset config is first fit over all 16 partitions. The table has no reset, so
    // every partition is loaded before the first allocate; from then on nothing
    // reads an unwritten entry. Sizes include zero, full scale and ties.
    sink_mode = 1;
    seed_caps = '{100, 0, 65535, 50, 50, 200, 65535, 10,
                  300, 50, 7, 1000, 0, 200, 20, 65535};
    for (k = 0; k < MAX_BLOCKS; k++) load_entry(k[3:0], seed_caps[k]);
    alloc_request(16'd0, 1'b0);       // zero request, first fit
    alloc_request(16'hFFFF, 1'b1);    // full-scale request empties a partition
    settle();

    // Best fit over the full table: tie on 50 goes low, zero request fits a zero slot.
    write_reg(REG_FIT_POLICY, CFG_DATA_W'(FIT_BEST));
    write_reg(REG_BLOCKS_IN_USE, 5'd16);
    alloc_request(16'd50, 1'b0);
    alloc_request(16'd0, 1'b1);
    settle();

    // Worst fit with an oversized search count (saturates to the table size).
    write_reg(REG_FIT_POLICY, CFG_DATA_W'(FIT_WORST));
    write_reg(REG_BLOCKS_IN_USE, 5'd31);
    alloc_request(16'd1, 1'b1);
    settle();

    // Reserved policy code acts as first fit; single partition searched.
    write_reg(REG_FIT_POLICY, CFG_DATA_W'(FIT_RESERVED));
    write_reg(REG_BLOCKS_IN_USE, 5'd1);
    alloc_request(16'd200, 1'b0);     // does not fit partition 0
    alloc_request(16'd50, 1'b1);
    settle();

    // Empty search: nothing can be granted.
    write_reg(REG_BLOCKS_IN_USE, 5'd0);
    alloc_request(16'd0, 1'b1);
    settle();
    directed_words = words_sent;

    // ---- Random part ----
    // Each phase: new config, then batches of reload-then-allocate with a value mix,
    // with stray reloads and stray batch marks mixed in as noise.
    while (words_sent < directed_words + RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      policy = (r < 3) ? FIT_FIRST : (r < 6) ? FIT_BEST : (r < 9) ? FIT_WORST : FIT_RESERVED;
      r = $urandom_range(0, 99);
      if (r < 8) count = 5'd0;
      else if (r < 18) count = 5'd1;
      else if (r < 33) count = 5'd16;
      else if (r < 43) count = 5'($urandom_range(17, 31));
      else count = 5'($urandom_range(2, 8));
      // upper bits of the policy word are don't-care; exercise them
      write_reg(REG_FIT_POLICY, {3'($urandom), policy});
      write_reg(REG_BLOCKS_IN_USE, count);
      src_mode  = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      phases++;
      span = (count == 0) ? 1 : (count > MAX_BLOCKS) ? MAX_BLOCKS : count;

      repeat ($urandom_range(2, 4)) begin
        mix = value_mix_e'($urandom_range(0, 3));
        // usually refill the searched partitions; otherwise keep depleting
        if ($urandom_range(0, 9) < 7) begin
          for (k = 0; k < span; k++) load_entry(k[3:0], draw_size(mix));
        end
        nreq = $urandom_range(3, 10);
        for (k = 0; k < nreq; k++) begin
          if ($urandom_range(0, 19) == 0) load_entry(4'($urandom), draw_size(mix));
          last = (k == nreq - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
          alloc_request(draw_size(mix), last);
          // once, at the head of a batch: hold off results while words keep coming
          if (!pressure_done && k == 0 && words_sent > directed_words + PRESSURE_AFTER) begin
            hold_request  = 1'b1;
            pressure_done = 1'b1;
          end
        end
      end
      settle();
    end

    $display("Run summary: %0d words accepted (%0d loads, %0d allocates) over %0d phases",
             sb.loads + sb.allocs, sb.loads, sb.allocs, phases);
    $display("Results checked: %0d (%0d granted, %0d refused), %0d mismatches",
             sb.checked, sb.grants, sb.refusals, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_cap_mem.sv
rtl/fpa_fit_cmp.sv
rtl/fit_policy_partition_allocator_top.sv
rtl/fpa_checker.sv
sim/tb_top.sv
